### src/gsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot pool: shared package
// Request and status codes, configuration and result structures, and the
// command word that travels from the intake side to the execution side.
// ----------------------------------------------------------------------------
package gsp_pkg;

  // Default sizes of the pool.
  localparam int SLOTS_DEFAULT    = 256;
  localparam int GEN_BITS_DEFAULT = 16;

  // Fixed field widths of the request and result words.
  localparam int REQ_W      = 2;
  localparam int INDEX_W    = 8;
  localparam int GEN_OUT_W  = 16;
  localparam int CAP_W      = 9;
  localparam int CNT_OUT_W  = 9;
  localparam int CFG_IDX_W  = 2;

  // Depth of the command queue between intake and execution.
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEFERRED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CAP  = 2'd1;

  localparam logic [CAP_W-1:0] MAX_CAP_RESET = 9'd256;

  // Request codes as they arrive on the request channel.
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_COLLECT = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_QUERY,
    OP_COLLECT
  } op_t;

  typedef enum logic [1:0] {
    SL_FREE    = 2'd0,
    SL_ACTIVE  = 2'd1,
    SL_PENDING = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    RES_DONE    = 2'd0,
    RES_FULL    = 2'd1,
    RES_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [INDEX_W-1:0]   idx;
    logic [GEN_OUT_W-1:0] hgen;
  } cmd_t;

  typedef struct packed {
    logic             deferred;
    logic [CAP_W-1:0] max_cap;
  } cfg_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   out_index;
    logic [GEN_OUT_W-1:0] out_generation;
    logic                 handle_valid;
    logic [CNT_OUT_W-1:0] total_slots;
    logic [CNT_OUT_W-1:0] active_count;
    logic [CNT_OUT_W-1:0] free_count;
    logic [CNT_OUT_W-1:0] pending_count;
  } result_t;

endpackage

### src/generational_slot_pool_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot pool core
// Hands out index plus generation handles from a pool of slots, with a LIFO
// free stack, deferred release and a garbage-collect sweep.
// ----------------------------------------------------------------------------
//
// Usage:
//   Requests enter on the s_axis channel, one result per request leaves on
//   the m_axis channel in request order. The cfg channel writes the two
//   registers (deferred release mode, capacity limit); the user must do so
//   only while the core is idle, which the core itself does not enforce.
//   A request passes an intake register and a two-entry command queue before
//   the execution stage, which works on one request at a time:
//     - full pool, or release/query of an index beyond high water: answered
//       from the idle state
//     - release, query, allocate by growing the pool: the S_EXEC state
//     - allocate from the free stack: stack read, then slot read
//     - garbage collect: one slot per cycle up to high water, and answered
//       from the idle state on an empty pool
//   The execution stage, with its single-port slot table reads, sets the
//   rate. Reset empties the pool without a clearing pass: the high water
//   mark bounds every read of the slot table.
//   If the receiver stalls, the finished result is held in the output
//   register and up to three further requests are taken into the intake
//   register and the queue before s_axis_tready drops.
//
module generational_slot_pool_core #(
  parameter int SLOTS    = gsp_pkg::SLOTS_DEFAULT,
  parameter int GEN_BITS = gsp_pkg::GEN_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, from bit 0: slot_index[7:0], handle_generation[15:0]
  input  logic [23:0]                     s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [gsp_pkg::REQ_W-1:0]       s_axis_tuser,
  // Result channel.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, from bit 0: status[1:0], out_index[7:0], out_generation[15:0],
  // handle_valid, total_slots[8:0], active_count[8:0], free_count[8:0],
  // pending_count[8:0], one zero pad bit
  output logic [63:0]                     m_axis_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsp_pkg::CAP_W-1:0]       cfg_data
);

  gsp_pkg::cfg_t    cfg;
  gsp_pkg::cmd_t    front_cmd;
  gsp_pkg::cmd_t    queue_cmd;
  gsp_pkg::result_t res;
  logic             front_valid;
  logic             front_ready;
  logic             queue_valid;
  logic             queue_ready;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deferred <= 1'b0;
      cfg.max_cap  <= gsp_pkg::MAX_CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gsp_pkg::REG_DEFERRED: cfg.deferred <= cfg_data[0];
        gsp_pkg::REG_MAX_CAP:  cfg.max_cap  <= cfg_data;
        default: ;
      endcase
    end
  end

  gsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_cmd   (front_cmd)
  );

  gsp_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_cmd   (queue_cmd)
  );

  gsp_back #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd_in    (queue_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // Result word, packed from the lowest bit up.
  assign m_axis_tdata = {1'b0,
                         res.pending_count,
                         res.free_count,
                         res.active_count,
                         res.total_slots,
                         res.handle_valid,
                         res.out_generation,
                         res.out_index,
                         res.status};

endmodule

### src/gsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot pool: intake stage
// Registers incoming requests and decodes the request code into a command.
// ----------------------------------------------------------------------------
module gsp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [23:0]                     in_data,
  input  logic [gsp_pkg::REQ_W-1:0]       in_user,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gsp_pkg::cmd_t                   out_cmd
);

  gsp_pkg::cmd_t decoded;
  logic          held;

  always_comb begin
    decoded.idx  = in_data[gsp_pkg::INDEX_W-1:0];
    decoded.hgen = in_data[gsp_pkg::INDEX_W +: gsp_pkg::GEN_OUT_W];
    unique case (in_user)
      gsp_pkg::REQ_ALLOC:   decoded.op = gsp_pkg::OP_ALLOC;
      gsp_pkg::REQ_RELEASE: decoded.op = gsp_pkg::OP_RELEASE;
      gsp_pkg::REQ_QUERY:   decoded.op = gsp_pkg::OP_QUERY;
      default:              decoded.op = gsp_pkg::OP_COLLECT;
    endcase
  end

  // The holding register frees up in the same cycle the queue takes it.
  assign in_ready  = !held || out_ready;
  assign out_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (out_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_cmd <= decoded;
    end
  end

endmodule

### src/gsp_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot pool: command queue
// Short first-in first-out buffer between the intake and execution stages.
// ----------------------------------------------------------------------------
module gsp_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gsp_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output gsp_pkg::cmd_t out_cmd
);

  localparam int DEPTH = gsp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gsp_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

### src/gsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot pool: execution stage
// Owns the slot table, the free stack and the pool counters, carries out one
// command at a time and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module gsp_back #(
  parameter int SLOTS    = gsp_pkg::SLOTS_DEFAULT,
  parameter int GEN_BITS = gsp_pkg::GEN_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  gsp_pkg::cfg_t    cfg,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  gsp_pkg::cmd_t    cmd_in,
  output logic             res_valid,
  input  logic             res_ready,
  output gsp_pkg::result_t res
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > gsp_pkg::CAP_W) ? CNT_W : gsp_pkg::CAP_W;
  localparam int GCMP_W = (GEN_BITS > gsp_pkg::GEN_OUT_W) ? GEN_BITS : gsp_pkg::GEN_OUT_W;
  localparam int SUM_W  = CNT_W + 2;
  localparam int IW     = gsp_pkg::INDEX_W;
  localparam int GW     = gsp_pkg::GEN_OUT_W;
  localparam int OCW    = gsp_pkg::CNT_OUT_W;

  typedef struct packed {
    gsp_pkg::slot_state_t st;
    logic [GEN_BITS-1:0]  gen;
  } slot_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STACK,
    S_EXEC,
    S_GC
  } state_t;

  // Slot table and free stack.
  slot_word_t       slot_mem  [SLOTS];
  logic [IDX_W-1:0] stack_mem [SLOTS];

  slot_word_t       mem_rd;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_word_t       mem_wd;

  logic [IDX_W-1:0] stk_rd;
  logic             stk_re;
  logic [IDX_W-1:0] stk_ra;
  logic             stk_we;
  logic [IDX_W-1:0] stk_wa;

  // Registers and their next values.
  state_t           state, state_next;
  gsp_pkg::cmd_t    cmd, cmd_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic             fresh, fresh_next;
  logic [CNT_W-1:0] free_top, free_top_next;
  logic [CNT_W-1:0] high_water, high_water_next;
  logic [CNT_W-1:0] active_total, active_total_next;
  logic [CNT_W-1:0] pending_total, pending_total_next;
  logic [CNT_W-1:0] gc_ptr, gc_ptr_next;
  logic [IDX_W-1:0] gc_prev, gc_prev_next;
  logic             gc_chk, gc_chk_next;
  logic             res_valid_next;
  gsp_pkg::result_t res_next;

  logic                 res_free;
  logic                 idx_ok;
  logic                 grow_ok;
  gsp_pkg::slot_state_t old_st;
  logic [GEN_BITS-1:0]  old_gen;
  logic [GEN_BITS-1:0]  gen_inc;
  logic                 gen_hit;
  logic                 push;
  logic [IDX_W-1:0]     push_idx;
  logic                 rsp;
  gsp_pkg::status_t     rsp_status;
  logic [IDX_W-1:0]     rsp_idx;
  logic [GEN_BITS-1:0]  rsp_gen;
  logic                 rsp_hit;

  assign res_free  = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE) && res_free;
  assign idx_ok    = CMP_W'(cmd_in.idx) < CMP_W'(high_water);
  assign grow_ok   = (high_water < CNT_W'(SLOTS)) &&
                     (CMP_W'(high_water) < CMP_W'(cfg.max_cap));

  // A slot just grown into has never been written since reset.
  assign old_st  = fresh ? gsp_pkg::SL_FREE : mem_rd.st;
  assign old_gen = fresh ? '0 : mem_rd.gen;
  assign gen_inc = old_gen + 1'b1;
  assign gen_hit = GCMP_W'(old_gen) == GCMP_W'(cmd.hgen);

  always_comb begin
    state_next         = state;
    cmd_next           = cmd;
    slot_next          = slot;
    fresh_next         = fresh;
    free_top_next      = free_top;
    high_water_next    = high_water;
    active_total_next  = active_total;
    pending_total_next = pending_total;
    gc_ptr_next        = gc_ptr;
    gc_prev_next       = gc_prev;
    gc_chk_next        = gc_chk;
    res_valid_next     = res_valid && !res_ready;
    res_next           = res;
    mem_re             = 1'b0;
    mem_ra             = slot;
    mem_we             = 1'b0;
    mem_wa             = slot;
    mem_wd             = mem_rd;
    stk_re             = 1'b0;
    stk_ra             = IDX_W'(free_top - 1'b1);
    stk_we             = 1'b0;
    stk_wa             = IDX_W'(free_top);
    push               = 1'b0;
    push_idx           = slot;
    rsp                = 1'b0;
    rsp_status         = gsp_pkg::RES_DONE;
    rsp_idx            = '0;
    rsp_gen            = '0;
    rsp_hit            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && res_free) begin
          cmd_next = cmd_in;
          unique case (cmd_in.op)
            gsp_pkg::OP_ALLOC: begin
              if (free_top != '0) begin
                stk_re     = 1'b1;
                state_next = S_STACK;
              end else if (grow_ok) begin
                slot_next  = IDX_W'(high_water);
                fresh_next = 1'b1;
                state_next = S_EXEC;
              end else begin
                rsp        = 1'b1;
                rsp_status = gsp_pkg::RES_FULL;
              end
            end
            gsp_pkg::OP_RELEASE, gsp_pkg::OP_QUERY: begin
              if (idx_ok) begin
                mem_re     = 1'b1;
                mem_ra     = IDX_W'(cmd_in.idx);
                slot_next  = IDX_W'(cmd_in.idx);
                fresh_next = 1'b0;
                state_next = S_EXEC;
              end else begin
                rsp        = 1'b1;
                rsp_status = (cmd_in.op == gsp_pkg::OP_RELEASE) ?
                             gsp_pkg::RES_IGNORED : gsp_pkg::RES_DONE;
              end
            end
            default: begin
              if (high_water == '0) begin
                rsp = 1'b1;
              end else begin
                gc_ptr_next = '0;
                gc_chk_next = 1'b0;
                state_next  = S_GC;
              end
            end
          endcase
        end
      end

      S_STACK: begin
        slot_next     = stk_rd;
        fresh_next    = 1'b0;
        free_top_next = free_top - 1'b1;
        mem_re        = 1'b1;
        mem_ra        = stk_rd;
        state_next    = S_EXEC;
      end

      S_EXEC: begin
        rsp        = 1'b1;
        state_next = S_IDLE;
        if (cmd.op == gsp_pkg::OP_ALLOC) begin
          mem_we     = 1'b1;
          mem_wd.st  = gsp_pkg::SL_ACTIVE;
          mem_wd.gen = gen_inc;
          if (old_st == gsp_pkg::SL_PENDING && pending_total != '0) begin
            pending_total_next = pending_total - 1'b1;
          end
          if (old_st != gsp_pkg::SL_ACTIVE) begin
            active_total_next = active_total + 1'b1;
          end
          if (fresh) begin
            high_water_next = high_water + 1'b1;
          end
          rsp_idx = slot;
          rsp_gen = gen_inc;
        end else if (cmd.op == gsp_pkg::OP_RELEASE) begin
          if (old_st != gsp_pkg::SL_ACTIVE) begin
            rsp_status = gsp_pkg::RES_IGNORED;
          end else begin
            active_total_next = active_total - 1'b1;
            mem_we            = 1'b1;
            mem_wd.gen        = old_gen;
            if (cfg.deferred) begin
              mem_wd.st          = gsp_pkg::SL_PENDING;
              pending_total_next = pending_total + 1'b1;
            end else begin
              mem_wd.st = gsp_pkg::SL_FREE;
              push      = 1'b1;
            end
          end
        end else begin
          rsp_hit = (old_st == gsp_pkg::SL_ACTIVE) && gen_hit;
        end
      end

      default: begin
        // Sweep: read slot gc_ptr while the slot read in the previous
        // cycle is checked and, if pending, freed and pushed.
        if (gc_chk && mem_rd.st == gsp_pkg::SL_PENDING) begin
          mem_we     = 1'b1;
          mem_wa     = gc_prev;
          mem_wd.st  = gsp_pkg::SL_FREE;
          mem_wd.gen = mem_rd.gen;
          push       = 1'b1;
          push_idx   = gc_prev;
          if (pending_total != '0) begin
            pending_total_next = pending_total - 1'b1;
          end
        end
        if (gc_ptr < high_water) begin
          mem_re       = 1'b1;
          mem_ra       = IDX_W'(gc_ptr);
          gc_prev_next = IDX_W'(gc_ptr);
          gc_ptr_next  = gc_ptr + 1'b1;
          gc_chk_next  = 1'b1;
        end else begin
          gc_chk_next = 1'b0;
          if (!gc_chk) begin
            rsp        = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
    endcase

    if (push && free_top < CNT_W'(SLOTS)) begin
      stk_we        = 1'b1;
      free_top_next = free_top + 1'b1;
    end

    if (rsp) begin
      res_valid_next          = 1'b1;
      res_next.status         = rsp_status;
      res_next.out_index      = IW'(rsp_idx);
      res_next.out_generation = GW'(rsp_gen);
      res_next.handle_valid   = rsp_hit;
      res_next.total_slots    = OCW'(high_water_next);
      res_next.active_count   = OCW'(active_total_next);
      res_next.free_count     = OCW'(free_top_next);
      res_next.pending_count  = OCW'(pending_total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fresh         <= 1'b0;
      free_top      <= '0;
      high_water    <= '0;
      active_total  <= '0;
      pending_total <= '0;
      gc_chk        <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      fresh         <= fresh_next;
      free_top      <= free_top_next;
      high_water    <= high_water_next;
      active_total  <= active_total_next;
      pending_total <= pending_total_next;
      gc_chk        <= gc_chk_next;
      res_valid     <= res_valid_next;
    end
    cmd     <= cmd_next;
    slot    <= slot_next;
    gc_ptr  <= gc_ptr_next;
    gc_prev <= gc_prev_next;
    res     <= res_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd <= slot_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= push_idx;
    end
    if (stk_re) begin
      stk_rd <= stack_mem[stk_ra];
    end
  end

  // A command only leaves the idle state when the result register is free,
  // so no result can be overwritten while a command is in flight.
  a_res_empty_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !res_valid)
    else $error("result register busy while a command executes");

  // Every grown slot is exactly one of free, active or pending.
  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (SUM_W'(active_total) + SUM_W'(pending_total) +
                           SUM_W'(free_top)) == SUM_W'(high_water))
    else $error("pool counts out of balance");

  a_high_water_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (high_water == $past(high_water)) ||
             (high_water == $past(high_water) + 1'b1))
    else $error("high water moved by more than one or shrank");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_GC) |-> (gc_ptr <= high_water))
    else $error("sweep pointer beyond high water");

endmodule

### bench/generational_slot_pool_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot pool core: testbench
// Sends allocate, release, query and garbage-collect requests under several
// capacity and release-mode settings, predicts every result with an in-bench
// model of the pool, and checks each result field by field.
// ----------------------------------------------------------------------------
module generational_slot_pool_core_tb;

  localparam int POOL_SLOTS     = 256;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PCT       = 35;

  localparam int REQ_W     = gsp_pkg::REQ_W;
  localparam int INDEX_W   = gsp_pkg::INDEX_W;
  localparam int GEN_OUT_W = gsp_pkg::GEN_OUT_W;
  localparam int CAP_W     = gsp_pkg::CAP_W;
  localparam int CNT_OUT_W = gsp_pkg::CNT_OUT_W;
  localparam int CFG_IDX_W = gsp_pkg::CFG_IDX_W;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the slot table, the free stack, the
  // counters and the two registers. Every accepted request is run through the
  // pool rules at once and its result is queued; results leave the core in
  // request order, so each one is compared with the oldest queued entry.
  // --------------------------------------------------------------------------
  class slot_pool_scoreboard;
    logic                 deferred_mode;
    logic [CAP_W-1:0]     capacity_limit;
    gsp_pkg::slot_state_t slot_st[POOL_SLOTS];
    logic [GEN_OUT_W-1:0] slot_gen[POOL_SLOTS];
    logic [INDEX_W-1:0]   free_stack[POOL_SLOTS];
    int unsigned          free_top;
    int unsigned          high_water;
    int unsigned          active_total;
    int unsigned          pending_total;
    gsp_pkg::result_t     awaited_results[$];
    int unsigned          errors;

    function new();
      deferred_mode  = 1'b0;
      capacity_limit = gsp_pkg::MAX_CAP_RESET;
      foreach (slot_st[i]) begin
        slot_st[i]    = gsp_pkg::SL_FREE;
        slot_gen[i]   = '0;
        free_stack[i] = '0;
      end
      free_top      = 0;
      high_water    = 0;
      active_total  = 0;
      pending_total = 0;
      errors        = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] value);
      if (idx == gsp_pkg::REG_DEFERRED) begin
        deferred_mode = value[0];
      end else if (idx == gsp_pkg::REG_MAX_CAP) begin
        capacity_limit = value;
      end
    endfunction

    function void push_free(int unsigned idx);
      if (free_top < POOL_SLOTS) begin
        free_stack[free_top] = idx[INDEX_W-1:0];
        free_top++;
      end
    endfunction

    // Applies one request to the pool copy and queues the result it causes.
    function void predict_pool_request(logic [REQ_W-1:0] req, logic [INDEX_W-1:0] idx,
                                       logic [GEN_OUT_W-1:0] hgen);
      gsp_pkg::result_t res;
      int unsigned      limit;
      int unsigned      s;
      bit               granted;
      res        = '0;
      res.status = gsp_pkg::RES_DONE;
      case (req)
        gsp_pkg::REQ_ALLOC: begin
          // A capacity above the table size behaves as the table size.
          limit   = (capacity_limit > POOL_SLOTS) ? POOL_SLOTS : capacity_limit;
          granted = 1'b1;
          s       = 0;
          if (free_top > 0) begin
            free_top--;
            s = free_stack[free_top];
          end else if (high_water < limit) begin
            s = high_water;
            high_water++;
          end else begin
            granted    = 1'b0;
            res.status = gsp_pkg::RES_FULL;
          end
          if (granted) begin
            if (slot_st[s] == gsp_pkg::SL_PENDING && pending_total > 0) pending_total--;
            if (slot_st[s] != gsp_pkg::SL_ACTIVE) active_total++;
            slot_st[s]         = gsp_pkg::SL_ACTIVE;
            slot_gen[s]        = slot_gen[s] + 1'b1;
            res.out_index      = s[INDEX_W-1:0];
            res.out_generation = slot_gen[s];
          end
        end
        gsp_pkg::REQ_RELEASE: begin
          if (idx >= high_water || slot_st[idx] != gsp_pkg::SL_ACTIVE) begin
            res.status = gsp_pkg::RES_IGNORED;
          end else begin
            active_total--;
            if (deferred_mode) begin
              slot_st[idx] = gsp_pkg::SL_PENDING;
              pending_total++;
            end else begin
              slot_st[idx] = gsp_pkg::SL_FREE;
              push_free(idx);
            end
          end
        end
        gsp_pkg::REQ_QUERY: begin
          res.handle_valid = (idx < high_water) && (slot_gen[idx] == hgen) &&
                             (slot_st[idx] == gsp_pkg::SL_ACTIVE);
        end
        default: begin
          // Garbage collect: ascending sweep over the grown part of the table.
          for (int unsigned i = 0; i < high_water; i++) begin
            if (slot_st[i] == gsp_pkg::SL_PENDING) begin
              slot_st[i] = gsp_pkg::SL_FREE;
              if (pending_total > 0) pending_total--;
              push_free(i);
            end
          end
        end
      endcase
      res.total_slots   = CNT_OUT_W'(high_water);
      res.active_count  = CNT_OUT_W'(active_total);
      res.free_count    = CNT_OUT_W'(free_top);
      res.pending_count = CNT_OUT_W'(pending_total);
      awaited_results.insert(awaited_results.size(), res);
    endfunction

    function void compare_field(string name, logic [GEN_OUT_W-1:0] want,
                                logic [GEN_OUT_W-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pool_result(logic [63:0] word);
      gsp_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, word);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", want.status, word[1:0]);
        compare_field("out_index", want.out_index, word[9:2]);
        compare_field("out_generation", want.out_generation, word[25:10]);
        compare_field("handle_valid", want.handle_valid, word[26]);
        compare_field("total_slots", want.total_slots, word[35:27]);
        compare_field("active_count", want.active_count, word[44:36]);
        compare_field("free_count", want.free_count, word[53:45]);
        compare_field("pending_count", want.pending_count, word[62:54]);
      end
    endfunction

    // Index of a random active slot, or -1 when none is active.
    function int pick_active();
      int hits[$];
      for (int i = 0; i < int'(high_water); i++) begin
        if (slot_st[i] == gsp_pkg::SL_ACTIVE) hits.insert(hits.size(), i);
      end
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1)];
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports.
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;
  logic [REQ_W-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [63:0]          m_axis_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0]     cfg_data;

  // When set, neither side inserts idle cycles.
  bit                   no_idling;
  int unsigned          stall_cycles = 0;

  slot_pool_scoreboard  pool_sb;

  generational_slot_pool_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random except during the no-idling stretch.
  always @(negedge clk) begin
    m_axis_tready <= no_idling || ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog. All handshakes are sampled at the rising edge; the
  // inputs only move at the falling edge, so the sampled values are stable.
  // The result is checked before the request of the same edge is noted, since
  // a result can never belong to a request taken in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) pool_sb.check_pool_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        pool_sb.predict_pool_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8]);
      end
      if (cfg_valid && cfg_ready) pool_sb.write_register(cfg_index, cfg_data);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("generational_slot_pool_core test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Called at a falling edge; it may first idle for a random
  // number of cycles, then holds the request until it is taken and returns at
  // the falling edge after that. Valid stays high into the next call, which
  // either replaces the request in the same step or lowers valid for a gap.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] idx,
                              input logic [GEN_OUT_W-1:0] hgen);
    int gap;
    gap = 0;
    if (!no_idling) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {hgen, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Lowers the request valid and waits until every result is back, then lets
  // a few more cycles pass before anything else touches the core.
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    while (pool_sb.awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Registers are only written while the core is idle.
  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CAP_W-1:0] value);
    drain_requests();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. Most releases and queries aim at live handles so that the
  // pool keeps cycling through its states; the rest are random indices and
  // generations, which also exercise the ignore and out-of-range paths.
  task automatic run_traffic_phase(input int count, input int alloc_pct,
                                   input int release_pct, input int query_pct);
    int                   roll;
    int                   pick;
    logic [INDEX_W-1:0]   idx;
    logic [GEN_OUT_W-1:0] hgen;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      pick = pool_sb.pick_active();
      idx  = (pick >= 0 && $urandom_range(9) < 8) ? pick[INDEX_W-1:0]
                                                  : INDEX_W'($urandom_range(255));
      if (roll < alloc_pct) begin
        send_request(gsp_pkg::REQ_ALLOC, INDEX_W'($urandom), GEN_OUT_W'($urandom));
      end else if (roll < alloc_pct + release_pct) begin
        send_request(gsp_pkg::REQ_RELEASE, idx, GEN_OUT_W'($urandom));
      end else if (roll < alloc_pct + release_pct + query_pct) begin
        case ($urandom_range(9))
          7:       hgen = pool_sb.slot_gen[idx] + 1'b1;
          8:       hgen = pool_sb.slot_gen[idx] - 1'b1;
          9:       hgen = GEN_OUT_W'($urandom);
          default: hgen = pool_sb.slot_gen[idx];
        endcase
        send_request(gsp_pkg::REQ_QUERY, idx, hgen);
      end else begin
        send_request(gsp_pkg::REQ_COLLECT, INDEX_W'($urandom), GEN_OUT_W'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    pool_sb       = new();
    rst           = 1'b1;
    no_idling     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = gsp_pkg::REQ_ALLOC;
    cfg_valid     = 1'b0;
    cfg_index     = gsp_pkg::REG_DEFERRED;
    cfg_data      = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, from the reset settings: immediate release, full capacity.
    // Requests against an empty pool are out of range or have nothing to do.
    send_request(gsp_pkg::REQ_QUERY, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_RELEASE, 8'd255, 16'hFFFF);
    send_request(gsp_pkg::REQ_RELEASE, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_COLLECT, 8'd0, 16'd0);
    // Grow the pool to three slots; unused fields carry all ones once.
    send_request(gsp_pkg::REQ_ALLOC, 8'hFF, 16'hFFFF);
    send_request(gsp_pkg::REQ_ALLOC, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_ALLOC, 8'd0, 16'd0);
    // A live handle, a stale generation, the top generation and an index far
    // beyond the high water mark.
    send_request(gsp_pkg::REQ_QUERY, 8'd1, 16'd1);
    send_request(gsp_pkg::REQ_QUERY, 8'd1, 16'd0);
    send_request(gsp_pkg::REQ_QUERY, 8'd2, 16'hFFFF);
    send_request(gsp_pkg::REQ_QUERY, 8'd255, 16'hFFFF);
    // Immediate release, a second release of the now free slot, a query of the
    // freed handle, then an allocate that reuses it from the free stack.
    send_request(gsp_pkg::REQ_RELEASE, 8'd1, 16'd0);
    send_request(gsp_pkg::REQ_RELEASE, 8'd1, 16'd0);
    send_request(gsp_pkg::REQ_QUERY, 8'd1, 16'd1);
    send_request(gsp_pkg::REQ_ALLOC, 8'd0, 16'd0);
    // Deferred release: the slot waits as pending, cannot be released again,
    // is not valid for queries, and returns to the stack only on collect.
    program_register(gsp_pkg::REG_DEFERRED, 9'd1);
    send_request(gsp_pkg::REQ_RELEASE, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_RELEASE, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_QUERY, 8'd0, 16'd1);
    send_request(gsp_pkg::REQ_ALLOC, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_COLLECT, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_ALLOC, 8'd0, 16'd0);
    // A limit below the high water mark stops growth, so with an empty stack
    // the allocate fails; after a collect the stack serves it again.
    program_register(gsp_pkg::REG_MAX_CAP, 9'd2);
    send_request(gsp_pkg::REQ_RELEASE, 8'd2, 16'd0);
    send_request(gsp_pkg::REQ_ALLOC, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_COLLECT, 8'd0, 16'd0);
    send_request(gsp_pkg::REQ_ALLOC, 8'd0, 16'd0);

    // Random part, over a series of settings. The high water mark never falls,
    // so small limits come first.
    program_register(gsp_pkg::REG_DEFERRED, 9'h0FE);
    program_register(gsp_pkg::REG_MAX_CAP, 9'd4);
    run_traffic_phase(150, 40, 30, 25);

    // No growth at all: only the free stack can serve. This phase also runs
    // without any idling on either side.
    program_register(gsp_pkg::REG_DEFERRED, 9'h1FF);
    program_register(gsp_pkg::REG_MAX_CAP, 9'd0);
    no_idling = 1'b1;
    run_traffic_phase(150, 35, 30, 25);
    no_idling = 1'b0;

    program_register(gsp_pkg::REG_MAX_CAP, 9'd40);
    run_traffic_phase(250, 40, 30, 25);

    // A limit above the table size: allocation-heavy so the pool fills up and
    // allocates start to fail.
    program_register(gsp_pkg::REG_DEFERRED, 9'd0);
    program_register(gsp_pkg::REG_MAX_CAP, 9'h1FF);
    run_traffic_phase(400, 70, 10, 15);

    program_register(gsp_pkg::REG_DEFERRED, 9'd1);
    program_register(gsp_pkg::REG_MAX_CAP, 9'd256);
    run_traffic_phase(400, 35, 35, 25);

    program_register(gsp_pkg::REG_DEFERRED, 9'd0);
    program_register(gsp_pkg::REG_MAX_CAP, 9'd100);
    run_traffic_phase(200, 40, 35, 20);

    // Wait for the last results, then watch a little longer for extra ones.
    drain_requests();
    repeat (20) @(posedge clk);
    if (pool_sb.errors == 0 && pool_sb.awaited_results.size() == 0) begin
      $display("generational_slot_pool_core test passed");
    end else begin
      $display("generational_slot_pool_core test failed");
    end
    $finish;
  end

endmodule

### files.f
src/gsp_pkg.sv
src/gsp_front.sv
src/gsp_cmd_queue.sv
src/gsp_back.sv
src/generational_slot_pool_core.sv
bench/generational_slot_pool_core_tb.sv
